// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition in the next cycle, checked through reset as well.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bmpd_pkg.sv
// Package with result kinds and default limits of the BMP stream decoder.
package bmpd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [2:0] KIND_PALETTE     = 3'd0;
  localparam logic [2:0] KIND_PIXEL       = 3'd1;
  localparam logic [2:0] KIND_HDR_OK      = 3'd2;
  localparam logic [2:0] KIND_HDR_UNSUPP  = 3'd3;
  localparam logic [2:0] KIND_HDR_ERROR   = 3'd4;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam int          HDR_BYTES     = 54;
  localparam int          OUT_DATA_W    = 88;

  typedef enum logic [1:0] {
    IDX_BYTE   = 2'd0,
    IDX_NIBBLE = 2'd1,
    IDX_BIT    = 2'd2
  } idx_mode_t;

endpackage

// File: sv/bmp_stream_decoder.sv
// Top level of the streaming decoder for uncompressed BMP files.
// Bytes of a BMP file enter one item per cycle unless in_tready is low; in_tuser marks the
// first byte of a new file. The 54-byte header yields one verdict item on offset 53, palette
// words one entry each, and each pixel byte 0, 1, 2 (4-bit) or up to 8 (1-bit) pixel items.
// Results leave one per cycle from an output register while out_tready allows; a new byte
// is taken once no earlier result is pending or the last one moves out, so 8-bit and 24-bit
// data run at one byte a cycle, while 1-bit data hold the input as their pixel items leave.
module bmp_stream_decoder
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] first_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [23:0] position, [31:24] color_index, [39:32] red, [47:40] green, [55:48] blue,
  // [68:56] image_width, [81:69] image_height, [86:82] bits_per_pixel, [87] last_of_image
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser,  // [2:0] kind
  output logic                  out_tlast   // last_of_run
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = WW + 3;
  localparam int PRW = WW + HW;

  typedef enum logic [2:0] {
    PH_HEADER, PH_PALETTE, PH_SKIP, PH_PIXELS, PH_IDLE
  } phase_t;

  // Parse state.
  phase_t          ph_r;
  logic [31:0]     off_r, hfs_r, w_r, h_r, pdo_r;
  logic [4:0]      dep_r;
  logic [3:0]      chk_r;
  logic [HW-1:0]   row_r;
  logic [PW-1:0]   rbc_r, pitch_r;
  logic [1:0]      m3_r;
  logic [WW-1:0]   col_r;
  logic [23:0]     base_r, pend_r;
  logic [8:0]      pal_r;
  logic [PRW-1:0]  prod_r;

  // Pending results of the current byte.
  logic [3:0]      bt_cnt_r;
  logic [2:0]      bt_kind_r;
  logic [23:0]     bt_pos_r;
  logic [7:0]      bt_idx_r;
  idx_mode_t       bt_mode_r;
  logic [7:0]      bt_red_r, bt_green_r, bt_blue_r;
  logic [12:0]     bt_w_r, bt_h_r;
  logic [4:0]      bt_bpp_r;
  logic            bt_ilast_r;

  // Output register.
  logic            out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [2:0]      out_kind_r;
  logic            out_last_r;

  // Next values.
  phase_t          ph_nxt;
  logic [31:0]     off_nxt, hfs_nxt, w_nxt, h_nxt, pdo_nxt;
  logic [4:0]      dep_nxt;
  logic [3:0]      chk_nxt;
  logic [HW-1:0]   row_nxt;
  logic [PW-1:0]   rbc_nxt, pitch_nxt;
  logic [1:0]      m3_nxt;
  logic [WW-1:0]   col_nxt;
  logic [23:0]     base_nxt, pend_nxt;
  logic [8:0]      pal_nxt;
  logic [3:0]      bt_cnt_nxt;
  logic [2:0]      bt_kind_nxt;
  logic [23:0]     bt_pos_nxt;
  logic [7:0]      bt_idx_nxt;
  idx_mode_t       bt_mode_nxt;
  logic [7:0]      bt_red_nxt, bt_green_nxt, bt_blue_nxt;
  logic [12:0]     bt_w_nxt, bt_h_nxt;
  logic [4:0]      bt_bpp_nxt;
  logic            bt_ilast_nxt;

  logic            move, accept;
  logic [7:0]      emit_idx;

  assign move      = (bt_cnt_r != 4'd0) && (!out_valid_r || out_tready);
  assign in_tready = (bt_cnt_r == 4'd0) || ((bt_cnt_r == 4'd1) && move);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    unique case (bt_mode_r)
      IDX_NIBBLE: emit_idx = {4'd0, bt_idx_r[7:4]};
      IDX_BIT:    emit_idx = {7'd0, bt_idx_r[7]};
      default:    emit_idx = bt_idx_r;
    endcase
  end

  always_comb begin
    logic [7:0]      b;
    logic [15:0]     hi;
    logic [31:0]     entries;
    logic [WW+5:0]   wd;
    logic [WW-1:0]   wl, rem, n;
    logic [31:0]     p;
    logic            wide_bad;
    b = in_tdata;
    ph_nxt = ph_r;   off_nxt = off_r;  hfs_nxt = hfs_r;  w_nxt = w_r;  h_nxt = h_r;
    pdo_nxt = pdo_r; dep_nxt = dep_r;  chk_nxt = chk_r;  row_nxt = row_r;
    rbc_nxt = rbc_r; pitch_nxt = pitch_r; m3_nxt = m3_r; col_nxt = col_r;
    base_nxt = base_r; pend_nxt = pend_r; pal_nxt = pal_r;
    if (in_tuser) begin
      ph_nxt = PH_HEADER; off_nxt = '0; hfs_nxt = '0; w_nxt = '0; h_nxt = '0;
      pdo_nxt = '0; dep_nxt = '0; chk_nxt = '0; row_nxt = '0; rbc_nxt = '0;
      pitch_nxt = '0; m3_nxt = '0; col_nxt = '0; base_nxt = '0; pend_nxt = '0;
      pal_nxt = '0;
    end
    bt_cnt_nxt = 4'd0; bt_kind_nxt = KIND_PIXEL; bt_pos_nxt = '0; bt_idx_nxt = '0;
    bt_mode_nxt = IDX_BYTE; bt_red_nxt = '0; bt_green_nxt = '0; bt_blue_nxt = '0;
    bt_w_nxt = '0; bt_h_nxt = '0; bt_bpp_nxt = '0; bt_ilast_nxt = 1'b0;
    hi = '0; entries = '0; wd = '0; n = '0; rem = '0; p = '0; wide_bad = 1'b0;
    wl = w_nxt[WW-1:0];

    if ((ph_nxt == PH_SKIP) && (off_nxt >= pdo_nxt)) ph_nxt = PH_PIXELS;

    unique case (ph_nxt)
      PH_HEADER: begin
        if (off_nxt < 32'(HDR_BYTES)) begin
          hfs_nxt = {b, hfs_nxt[31:8]};
          hi = hfs_nxt[31:16];
          unique case (off_nxt)
            32'd1:  if (hi != BMP_SIGNATURE) chk_nxt[0] = 1'b1;
            32'd13: pdo_nxt = hfs_nxt;
            32'd21: w_nxt = hfs_nxt;
            32'd25: h_nxt = hfs_nxt;
            32'd27: if (hi != 16'd1) chk_nxt[1] = 1'b1;
            32'd29: begin
              dep_nxt = hi[4:0];
              if (hi != 16'd1 && hi != 16'd4 && hi != 16'd8 && hi != 16'd24)
                chk_nxt[3] = 1'b1;
            end
            32'd33: if (hfs_nxt != 32'd0) chk_nxt[2] = 1'b1;
            32'd53: begin
              unique case (dep_nxt)
                5'd1:    entries = 32'd2;
                5'd4:    entries = 32'd16;
                5'd8:    entries = 32'd256;
                default: entries = 32'd0;
              endcase
              wide_bad = (w_nxt == 32'd0) || (w_nxt > 32'(MAX_WIDTH)) ||
                         (h_nxt > 32'(MAX_HEIGHT)) || (32'(prod_r) > 32'h0100_0000) ||
                         (pdo_nxt < 32'(HDR_BYTES) + {entries[29:0], 2'b00});
              bt_cnt_nxt = 4'd1;
              bt_w_nxt = w_nxt[12:0];
              bt_h_nxt = h_nxt[12:0];
              bt_bpp_nxt = dep_nxt;
              priority if (chk_nxt != 4'd0) bt_kind_nxt = KIND_HDR_UNSUPP;
              else if (wide_bad)            bt_kind_nxt = KIND_HDR_ERROR;
              else                          bt_kind_nxt = KIND_HDR_OK;
              if (bt_kind_nxt != KIND_HDR_OK) begin
                ph_nxt = PH_IDLE;
              end else begin
                pal_nxt = entries[8:0];
                unique case (dep_nxt)
                  5'd1:    wd = (WW+6)'(wl);
                  5'd4:    wd = (WW+6)'({wl, 2'b00});
                  5'd8:    wd = (WW+6)'({wl, 3'b000});
                  default: wd = (WW+6)'({wl, 4'b0000}) + (WW+6)'({wl, 3'b000});
                endcase
                wd = wd + (WW+6)'(31);
                pitch_nxt = PW'({wd[WW+5:5], 2'b00});
                row_nxt = '0; rbc_nxt = '0; col_nxt = '0; pend_nxt = '0; m3_nxt = '0;
                base_nxt = (h_nxt != 32'd0) ? 24'(prod_r - PRW'(wl)) : 24'd0;
                if (entries != 32'd0)      ph_nxt = PH_PALETTE;
                else if (h_nxt != 32'd0)   ph_nxt = PH_SKIP;
                else                       ph_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end else begin
          ph_nxt = PH_IDLE;
        end
      end
      PH_PALETTE: begin
        p = off_nxt - 32'(HDR_BYTES);
        if (p[1:0] != 2'd3) begin
          pend_nxt = {pend_nxt[15:0], b};
        end else begin
          bt_cnt_nxt = 4'd1;
          bt_kind_nxt = KIND_PALETTE;
          bt_pos_nxt = {16'd0, p[9:2]};
          bt_idx_nxt = p[9:2];
          bt_red_nxt = pend_nxt[7:0];
          bt_green_nxt = pend_nxt[15:8];
          bt_blue_nxt = pend_nxt[23:16];
          if ({1'b0, p[9:2]} + 9'd1 >= pal_nxt)
            ph_nxt = (h_nxt != 32'd0) ? PH_SKIP : PH_IDLE;
        end
      end
      PH_PIXELS: begin
        rem = wl - col_nxt;
        bt_pos_nxt = base_nxt + 24'(col_nxt);
        bt_idx_nxt = b;
        unique case (dep_nxt)
          5'd8: begin
            n = (rem != '0) ? WW'(1) : '0;
          end
          5'd4: begin
            bt_mode_nxt = IDX_NIBBLE;
            n = (rem >= WW'(2)) ? WW'(2) : rem;
          end
          5'd1: begin
            bt_mode_nxt = IDX_BIT;
            n = (rem >= WW'(8)) ? WW'(8) : rem;
          end
          default: begin
            pend_nxt = {pend_nxt[15:0], b};
            bt_idx_nxt = '0;
            bt_red_nxt = pend_nxt[7:0];
            bt_green_nxt = pend_nxt[15:8];
            bt_blue_nxt = pend_nxt[23:16];
            n = ((m3_nxt == 2'd2) && (rem != '0)) ? WW'(1) : '0;
          end
        endcase
        bt_cnt_nxt = n[3:0];
        bt_ilast_nxt = (n != '0) && (32'(row_nxt) + 32'd1 == h_nxt) &&
                       (col_nxt + n == wl);
        col_nxt = col_nxt + n;
        m3_nxt = (m3_nxt == 2'd2) ? 2'd0 : m3_nxt + 2'd1;
        rbc_nxt = rbc_nxt + PW'(1);
        if (rbc_nxt >= pitch_nxt) begin
          rbc_nxt = '0; col_nxt = '0; m3_nxt = '0;
          row_nxt = row_nxt + HW'(1);
          if (32'(row_nxt) >= h_nxt) ph_nxt = PH_IDLE;
          else                       base_nxt = base_nxt - 24'(wl);
        end
      end
      default: ;
    endcase
    if (off_nxt != 32'hFFFF_FFFF) off_nxt = off_nxt + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER;
      off_r <= '0; hfs_r <= '0; w_r <= '0; h_r <= '0; pdo_r <= '0; dep_r <= '0;
      chk_r <= '0; row_r <= '0; rbc_r <= '0; pitch_r <= '0; m3_r <= '0; col_r <= '0;
      base_r <= '0; pend_r <= '0; pal_r <= '0;
      bt_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ph_r <= ph_nxt; off_r <= off_nxt; hfs_r <= hfs_nxt; w_r <= w_nxt; h_r <= h_nxt;
        pdo_r <= pdo_nxt; dep_r <= dep_nxt; chk_r <= chk_nxt; row_r <= row_nxt;
        rbc_r <= rbc_nxt; pitch_r <= pitch_nxt; m3_r <= m3_nxt; col_r <= col_nxt;
        base_r <= base_nxt; pend_r <= pend_nxt; pal_r <= pal_nxt;
        bt_cnt_r <= bt_cnt_nxt;
      end else if (move) begin
        bt_cnt_r <= bt_cnt_r - 4'd1;
      end
      if (move)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    // Product for the size check and the bottom row base; stable well before the verdict.
    prod_r <= w_r[WW-1:0] * h_r[HW-1:0];
    if (accept) begin
      bt_kind_r <= bt_kind_nxt; bt_pos_r <= bt_pos_nxt; bt_idx_r <= bt_idx_nxt;
      bt_mode_r <= bt_mode_nxt; bt_red_r <= bt_red_nxt; bt_green_r <= bt_green_nxt;
      bt_blue_r <= bt_blue_nxt; bt_w_r <= bt_w_nxt; bt_h_r <= bt_h_nxt;
      bt_bpp_r <= bt_bpp_nxt; bt_ilast_r <= bt_ilast_nxt;
    end else if (move) begin
      bt_pos_r <= bt_pos_r + 24'd1;
      unique case (bt_mode_r)
        IDX_NIBBLE: bt_idx_r <= {bt_idx_r[3:0], 4'd0};
        IDX_BIT:    bt_idx_r <= {bt_idx_r[6:0], 1'b0};
        default:    bt_idx_r <= bt_idx_r;
      endcase
    end
    if (move) begin
      out_kind_r <= bt_kind_r;
      out_last_r <= (bt_cnt_r == 4'd1);
      out_data_r <= {bt_ilast_r && (bt_cnt_r == 4'd1), bt_bpp_r, bt_h_r, bt_w_r,
                     bt_blue_r, bt_green_r, bt_red_r, emit_idx, bt_pos_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// File: sv/bmpd_checker.sv
// Port checker for the BMP stream decoder and its bind statement.
`include "assert_macros.svh"

module bmpd_checker
  import bmpd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]            out_tuser,
  input logic                  out_tlast
);

  `ASSERT_NEXT(a_reset_quiet, !rst_n, !out_tvalid, "result valid right after reset")
  `ASSERT_IMPL(a_kind_range, out_tvalid, out_tuser <= KIND_HDR_ERROR, "unknown result kind")
  `ASSERT_IMPL(a_image_end, out_tvalid && out_tdata[OUT_DATA_W-1],
               out_tlast && (out_tuser == KIND_PIXEL), "image end not on last pixel of a byte")
  `ASSERT_IMPL(a_hold, out_tvalid && !out_tready,
               ##1 (out_tvalid && $stable(out_tdata)), "stalled item dropped or changed")

endmodule

bind bmp_stream_decoder bmpd_checker u_bmpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
